// ===== rtl/lst_pkg.sv =====
// Shared constants, controller state codes and command/status types for the texture filter.
package lst_pkg;

    localparam int PIX_W          = 8;
    localparam int RGB_W          = 3 * PIX_W;
    localparam int CFG_W          = 11;
    localparam int SCORE_W        = 15;
    localparam int COORD_W        = 10;
    localparam int ROW_W          = 10;
    localparam int MAX_HEIGHT     = 1024;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_SCORE_FRAC = 4;
    localparam int SUM_W          = 12;  // total of nine 8-bit samples
    localparam int SQSUM_W        = 20;  // total of nine squared samples
    localparam int DIFF_W         = 23;  // 9*Q and S*S
    localparam int WIN_TAPS       = 9;
    localparam int LANES          = 3;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    localparam logic [SCORE_W-1:0] SCORE_MAX  = 15'h7fff;
    localparam logic [CFG_W-1:0]   RST_WIDTH  = 11'd1024;
    localparam logic [CFG_W-1:0]   RST_HEIGHT = 11'd768;
    localparam logic [CFG_W-1:0]   MIN_DIM    = 11'd3;

    // Register index decoded from paddr[2]
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_READ   = 8'b0000_0010,
        ST_ACC    = 8'b0000_0100,
        ST_SQUARE = 8'b0000_1000,
        ST_DIFF   = 8'b0001_0000,
        ST_ROOT   = 8'b0010_0000,
        ST_DIV    = 8'b0100_0000,
        ST_SUM    = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic capture;
        logic update;
        logic acc;
        logic square;
        logic diff;
        logic root_step;
        logic div;
        logic sum;
    } t_cmd;

    typedef struct packed {
        logic interior;
        logic out_full;
    } t_sts;

endpackage

// ===== rtl/lst_pix_if.sv =====
// Input pixel channel: valid/ready handshake with one RGB word and a frame start flag.
interface lst_pix_if;
    import lst_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_start;

    modport source (output valid, red, green, blue, frame_start, input ready);
    modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

// ===== rtl/lst_res_if.sv =====
// Result channel: valid/ready handshake with the texture score and its centre position.
interface lst_res_if;
    import lst_pkg::*;
    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] texture_score;
    logic [COORD_W-1:0] centre_column;
    logic [COORD_W-1:0] centre_row;
    logic               frame_end;

    modport source (output valid, texture_score, centre_column, centre_row, frame_end,
                    input ready);
    modport sink   (input valid, texture_score, centre_column, centre_row, frame_end,
                    output ready);
endinterface

// ===== rtl/lst_ctrl.sv =====
// Controller state machine sequencing one pixel through the filter datapath.
module lst_ctrl
    import lst_pkg::*;
#(
    parameter int ROOT_STEPS = 14
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int CNT_MAX = (ROOT_STEPS > WIN_TAPS) ? ROOT_STEPS : WIN_TAPS;
    localparam int CNT_W   = $clog2(CNT_MAX);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.update = 1'b1;
                n_cnt        = '0;
                n_state      = i_sts.interior ? ST_ACC : ST_IDLE;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WIN_TAPS - 1)) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_cnt      = '0;
                n_state    = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_STEPS - 1)) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = ST_SUM;
            end
            ST_SUM: begin
                if (!i_sts.out_full) begin
                    o_cmd.sum = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== rtl/lst_datapath.sv =====
// Datapath: line stores, window, moment sums, square-root lanes and output word register.
module lst_datapath
    import lst_pkg::*;
#(
    parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
    parameter int SCORE_FRAC_BITS = DEF_SCORE_FRAC,
    parameter int ROOT_STEPS      = (DIFF_W + 2 * SCORE_FRAC_BITS + 1) / 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [CFG_W-1:0]   i_frame_width,
    input  logic [CFG_W-1:0]   i_frame_height,
    input  logic [PIX_W-1:0]   i_red,
    input  logic [PIX_W-1:0]   i_green,
    input  logic [PIX_W-1:0]   i_blue,
    input  logic               i_frame_start,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [SCORE_W-1:0] o_texture_score,
    output logic [COORD_W-1:0] o_centre_column,
    output logic [COORD_W-1:0] o_centre_row,
    output logic               o_frame_end
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CMPW  = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int COLX  = (CW > COORD_W) ? CW : COORD_W;
    localparam int RW    = ROOT_STEPS;
    localparam int XPW   = 2 * RW;
    localparam int NSH   = RW + 1;
    localparam int PW    = RW + NSH;
    localparam int SW    = (RW + 2 > SCORE_W + 1) ? RW + 2 : SCORE_W + 1;
    localparam logic [NSH-1:0] KMUL      = NSH'(((1 << NSH) + 2) / 3);
    localparam logic [RW-1:0]  ZERO_ROOT = RW'(3) << SCORE_FRAC_BITS;

    // Line stores
    logic [RGB_W-1:0] r_upper  [MAX_WIDTH];
    logic [RGB_W-1:0] r_middle [MAX_WIDTH];
    logic [RGB_W-1:0] r_top, r_mid, r_pix;

    logic [CW-1:0]    r_colc, r_col, col_eff;
    logic [ROW_W-1:0] r_rowc, r_row;

    logic [RGB_W-1:0] r_wcol [6];
    logic [RGB_W-1:0] r_win  [WIN_TAPS];

    logic [SUM_W-1:0]   r_s   [LANES];
    logic [SQSUM_W-1:0] r_q   [LANES];
    logic [DIFF_W-1:0]  r_ss  [LANES];
    logic [DIFF_W-1:0]  r_q9  [LANES];
    logic               r_zero[LANES];
    logic [XPW-1:0]     r_x   [LANES];
    logic [RW:0]        r_rem [LANES];
    logic [RW-1:0]      r_root[LANES];
    logic [RW-1:0]      r_third[LANES];

    logic [COORD_W-1:0] r_ccol, r_crow;
    logic               r_cend;

    logic [CMPW-1:0]    wid, col_next;
    logic [CFG_W-1:0]   hgt, row_next;
    logic [COLX-1:0]    col_m1;
    logic               col_wrap, row_wrap;
    logic [SW-1:0]      total;

    assign col_eff = i_frame_start ? '0 : r_colc;

    // Clamp geometry
    always_comb begin
        wid = CMPW'(i_frame_width);
        if (i_frame_width < MIN_DIM) begin
            wid = CMPW'(MIN_DIM);
        end else if (CMPW'(i_frame_width) > CMPW'(MAX_WIDTH)) begin
            wid = CMPW'(MAX_WIDTH);
        end
        hgt = i_frame_height;
        if (i_frame_height < MIN_DIM) begin
            hgt = MIN_DIM;
        end else if (i_frame_height > CFG_W'(MAX_HEIGHT)) begin
            hgt = CFG_W'(MAX_HEIGHT);
        end
    end

    assign col_next = CMPW'(r_col) + 1'b1;
    assign row_next = CFG_W'(r_row) + 1'b1;
    assign col_wrap = col_next >= wid;
    assign row_wrap = row_next >= hgt;
    assign col_m1   = COLX'(r_col) - 1'b1;

    assign o_sts.interior = (r_col >= CW'(2)) && (r_row >= ROW_W'(2));
    assign o_sts.out_full = o_out_valid && !i_out_ready;

    // Line store access: read at capture, write back in the next cycle at update
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_top <= r_upper[col_eff];
            r_mid <= r_middle[col_eff];
            r_pix <= {i_red, i_green, i_blue};
            r_col <= col_eff;
            r_row <= i_frame_start ? '0 : r_rowc;
        end
        if (i_cmd.update) begin
            r_upper[r_col]  <= r_mid;
            r_middle[r_col] <= r_pix;
        end
    end

    // Position counters and window columns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colc <= '0;
            r_rowc <= '0;
            for (int i = 0; i < 6; i++) begin
                r_wcol[i] <= '0;
            end
        end else if (i_cmd.update) begin
            if (col_wrap) begin
                r_colc <= '0;
                r_rowc <= row_wrap ? '0 : row_next[ROW_W-1:0];
            end else begin
                r_colc <= col_next[CW-1:0];
            end
            r_wcol[0] <= r_wcol[3];
            r_wcol[1] <= r_wcol[4];
            r_wcol[2] <= r_wcol[5];
            r_wcol[3] <= r_top;
            r_wcol[4] <= r_mid;
            r_wcol[5] <= r_pix;
        end else if (i_cmd.capture && i_frame_start) begin
            r_colc <= '0;
            r_rowc <= '0;
        end
    end

    // Window, moments, root and divide
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= r_wcol[i];
            end
            r_win[6] <= r_top;
            r_win[7] <= r_mid;
            r_win[8] <= r_pix;
            for (int c = 0; c < LANES; c++) begin
                r_s[c] <= '0;
                r_q[c] <= '0;
            end
            r_ccol <= col_m1[COORD_W-1:0];
            r_crow <= r_row - 1'b1;
            r_cend <= col_wrap && row_wrap;
        end
        if (i_cmd.acc) begin
            for (int i = 0; i < WIN_TAPS - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            for (int c = 0; c < LANES; c++) begin
                r_s[c] <= r_s[c] + SUM_W'(r_win[0][RGB_W-1-PIX_W*c -: PIX_W]);
                r_q[c] <= r_q[c] + SQSUM_W'(r_win[0][RGB_W-1-PIX_W*c -: PIX_W]
                                            * r_win[0][RGB_W-1-PIX_W*c -: PIX_W]);
            end
        end
        if (i_cmd.square) begin
            for (int c = 0; c < LANES; c++) begin
                r_ss[c]   <= DIFF_W'(r_s[c]) * DIFF_W'(r_s[c]);
                r_q9[c]   <= (DIFF_W'(r_q[c]) << 3) + DIFF_W'(r_q[c]);
                r_zero[c] <= (r_s[c] == '0);
            end
        end
        if (i_cmd.diff) begin
            for (int c = 0; c < LANES; c++) begin
                r_x[c]    <= XPW'(r_q9[c] - r_ss[c]) << (2 * SCORE_FRAC_BITS);
                r_rem[c]  <= '0;
                r_root[c] <= '0;
            end
        end
        if (i_cmd.root_step) begin
            for (int c = 0; c < LANES; c++) begin
                if ({r_rem[c], r_x[c][XPW-1 -: 2]} >= {1'b0, r_root[c], 2'b01}) begin
                    r_rem[c]  <= (RW+1)'({r_rem[c], r_x[c][XPW-1 -: 2]}
                                         - {1'b0, r_root[c], 2'b01});
                    r_root[c] <= {r_root[c][RW-2:0], 1'b1};
                end else begin
                    r_rem[c]  <= (RW+1)'({r_rem[c], r_x[c][XPW-1 -: 2]});
                    r_root[c] <= {r_root[c][RW-2:0], 1'b0};
                end
                r_x[c] <= r_x[c] << 2;
            end
        end
        if (i_cmd.div) begin
            for (int c = 0; c < LANES; c++) begin
                r_third[c] <= r_zero[c] ? ZERO_ROOT
                            : RW'((PW'(r_root[c]) * PW'(KMUL)) >> NSH);
            end
        end
    end

    assign total = SW'(r_third[0]) + SW'(r_third[1]) + SW'(r_third[2]);

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.sum) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            o_texture_score <= (total > SW'(SCORE_MAX)) ? SCORE_MAX : total[SCORE_W-1:0];
            o_centre_column <= r_ccol;
            o_centre_row    <= r_crow;
            o_frame_end     <= r_cend;
        end
    end

endmodule

// ===== rtl/local_stddev_texture_3x3.sv =====
// Top level of the 3x3 local standard deviation texture filter.
// RGB pixels enter in raster order on i_pix, one word at a time; each accepted word
// is written to two line stores and completes a 3x3 window centred one column left
// and one row up. For every centre off the frame border a result word on o_res gives
// the sum over red, green and blue of sqrt(sum of squared deviations from the mean),
// unsigned with SCORE_FRAC_BITS fraction bits, truncated per channel and saturated to
// 15 bits; a channel whose nine samples are all zero scores exactly 3. Border pixels
// produce no result word. A word with frame_start high is placed at column 0, row 0.
// Timing: a border pixel passes only through the idle and read states; an interior
// pixel also steps through accumulation over the nine window taps, squaring, the
// difference, ROOT_STEPS = (23 + 2*SCORE_FRAC_BITS + 1)/2 one-bit-per-cycle
// square-root steps, the divide by three and the output sum. The controller steps
// one pixel at a time through a single-port line store read/write. The next pixel is
// accepted while a finished result word still waits on o_res. Frame width and height
// are APB registers at offsets 0x0 and 0x4 (clamped to 3..MAX_WIDTH and 3..1024) and
// must be written only while the block is idle. The line stores need no clearing
// after reset.
module local_stddev_texture_3x3
    import lst_pkg::*;
#(
    parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
    parameter int SCORE_FRAC_BITS = DEF_SCORE_FRAC
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lst_pix_if.sink           i_pix,
    lst_res_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int ROOT_STEPS = (DIFF_W + 2 * SCORE_FRAC_BITS + 1) / 2;

    logic [CFG_W-1:0] r_frame_width, r_frame_height;
    t_cmd             cmd;
    t_sts             sts;

    // Configuration registers: write on the access phase
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_WIDTH;
            r_frame_height <= RST_HEIGHT;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    lst_ctrl #(
        .ROOT_STEPS (ROOT_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lst_datapath #(
        .MAX_WIDTH       (MAX_WIDTH),
        .SCORE_FRAC_BITS (SCORE_FRAC_BITS),
        .ROOT_STEPS      (ROOT_STEPS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_frame_width   (r_frame_width),
        .i_frame_height  (r_frame_height),
        .i_red           (i_pix.red),
        .i_green         (i_pix.green),
        .i_blue          (i_pix.blue),
        .i_frame_start   (i_pix.frame_start),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_texture_score (o_res.texture_score),
        .o_centre_column (o_res.centre_column),
        .o_centre_row    (o_res.centre_row),
        .o_frame_end     (o_res.frame_end)
    );

endmodule
